>>> rtl/core/lsil_pkg.sv
// ----------------------------------------------------------------------------
// lsil_pkg
// Shared types and constants for the line start index lookup block.
// ----------------------------------------------------------------------------
package lsil_pkg;

  // table geometry
  localparam int MAX_LINES = 4096;
  localparam int IDX_W     = $clog2(MAX_LINES);
  localparam int CNT_W     = IDX_W + 1;

  // field widths
  localparam int OFF_W  = 32;
  localparam int LINE_W = 13;
  localparam int COL_W  = 33;

  // action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_CAP  = 2'd2;

  // character codes and size cap
  localparam logic [7:0]       CHAR_LF  = 8'h0A;
  localparam logic [7:0]       CHAR_CR  = 8'h0D;
  localparam logic [OFF_W-1:0] SIZE_CAP = '1;

  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       byte_value;
    logic [OFF_W-1:0] offset;
  } in_item_t;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
    logic [1:0]        status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_READ,
    S_CMP,
    S_FIN,
    S_DONE
  } state_t;

endpackage

>>> rtl/core/line_start_index_lookup.sv
// Appends, clears and unknown actions are taken in the idle state and handed
// to the output register from the done state, which waits while the output
// is stalled; no new beat is taken until the block is back in idle.
// A query runs a binary search over the line start table with one shared
// compare unit and a table memory with one write and one registered read:
// each halving step takes a read state (address out) and a compare state on
// the registered read data. The block takes no new beat while a query is in
// the search. Entry 0 of the table is fixed at zero and never stored, so no
// clearing pass is needed after reset or clear.
// ----------------------------------------------------------------------------
// line_start_index_lookup
// Records line start offsets of a byte stream and maps byte offsets to
// 1-based line and column by binary search over the start table.
// ----------------------------------------------------------------------------
module line_start_index_lookup
  import lsil_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // table storage, entry 0 implied zero
  logic [OFF_W-1:0] mem [MAX_LINES];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  line_count_r;
  logic [OFF_W-1:0]  text_size_r;
  logic              pending_r;
  logic              out_valid_r;
  out_item_t         out_r;
  out_item_t         res_r;
  out_item_t         res_load;
  logic [OFF_W-1:0]  off_r;
  logic [CNT_W-1:0]  lo_r, hi_r, mid_r;
  logic [OFF_W-1:0]  start_r;
  logic [OFF_W-1:0]  rd_r;
  logic              rd_zero_r;

  logic              accept;
  logic              out_free;
  logic [CNT_W-1:0]  mid;
  logic [OFF_W-1:0]  rd_data;

  // shared compare unit
  logic [OFF_W-1:0]  cmp_a, cmp_b;
  logic              cmp_le;

  // append decode
  logic              is_lf, is_cr;
  logic              push_en;
  logic              tbl_full;
  logic              wr_en;
  logic [OFF_W-1:0]  push_val;
  logic [1:0]        app_status;

  // final answer
  logic              pend_hit;
  logic [LINE_W-1:0] fin_line;
  logic [OFF_W-1:0]  fin_start;
  logic [COL_W-1:0]  fin_col;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_data  = rd_zero_r ? '0 : rd_r;

  // compare operand select per sequencer step
  always_comb begin
    case (state_r)
      S_SETUP: begin
        cmp_a = res_r.column[OFF_W-1:0];
        cmp_b = text_size_r;
      end
      S_CMP: begin
        cmp_a = rd_data;
        cmp_b = off_r;
      end
      default: begin
        cmp_a = text_size_r;
        cmp_b = off_r;
      end
    endcase
  end
  assign cmp_le = (cmp_a <= cmp_b);

  // append decode
  assign is_lf      = (in_data.byte_value == CHAR_LF);
  assign is_cr      = (in_data.byte_value == CHAR_CR);
  assign push_en    = pending_r || is_lf;
  assign push_val   = is_lf ? text_size_r + 1'b1 : text_size_r;
  assign tbl_full   = (line_count_r == CNT_W'(MAX_LINES));
  assign wr_en      = accept && (in_data.action == ACT_APPEND) &&
                      (text_size_r != SIZE_CAP) && push_en && !tbl_full;
  assign app_status = (text_size_r == SIZE_CAP) ? ST_CAP :
                      (push_en && tbl_full)     ? ST_FULL : ST_OK;

  // answer assembly after the search
  assign pend_hit  = pending_r && !tbl_full && cmp_le;
  assign fin_line  = pend_hit ? LINE_W'(line_count_r + 1'b1) : LINE_W'(lo_r);
  assign fin_start = pend_hit ? text_size_r : start_r;
  assign fin_col   = {1'b0, off_r - fin_start} + COL_W'(1);

  // result seed for an accepted beat; a query holds the raw offset in the
  // column field until clamped
  always_comb begin
    res_load = '0;
    if (in_data.action == ACT_APPEND) begin
      res_load.status = app_status;
    end
    if (in_data.action == ACT_QUERY) begin
      res_load.column = {1'b0, in_data.offset};
    end
  end

  // sequencer next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = (in_data.action == ACT_QUERY) ? S_SETUP : S_DONE;
        end
      end
      S_SETUP: state_nxt = S_READ;
      S_READ:  state_nxt = (lo_r < hi_r) ? S_CMP : S_FIN;
      S_CMP:   state_nxt = S_READ;
      S_FIN:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // text state: line count, size and pending cr
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= CNT_W'(1);
      text_size_r  <= '0;
      pending_r    <= 1'b0;
    end else if (accept) begin
      case (in_data.action)
        ACT_CLEAR: begin
          line_count_r <= CNT_W'(1);
          text_size_r  <= '0;
          pending_r    <= 1'b0;
        end
        ACT_APPEND: begin
          if (text_size_r != SIZE_CAP) begin
            text_size_r <= text_size_r + 1'b1;
            pending_r   <= is_cr;
            if (wr_en) begin
              line_count_r <= line_count_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[line_count_r[IDX_W-1:0]] <= push_val;
    end
    if (state_r == S_READ) begin
      rd_r      <= mem[mid[IDX_W-1:0]];
      rd_zero_r <= (mid == '0);
    end
  end

  // search registers and pending result
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_r <= res_load;
        end
      end
      S_SETUP: begin
        off_r   <= cmp_le ? cmp_a : cmp_b;
        lo_r    <= '0;
        hi_r    <= line_count_r;
        start_r <= '0;
      end
      S_READ: begin
        mid_r <= mid;
      end
      S_CMP: begin
        if (cmp_le) begin
          lo_r    <= mid_r + 1'b1;
          start_r <= rd_data;
        end else begin
          hi_r <= mid_r;
        end
      end
      S_FIN: begin
        res_r <= {fin_line, fin_col, ST_OK};
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // search window stays ordered while comparing
  a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (mid_r >= lo_r) && (mid_r < hi_r))
    else $error("search midpoint outside window");

  // entry 0 always satisfies the compare, so the search never ends at zero
  a_fin_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (lo_r != '0))
    else $error("search ended without a start");

  // line count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (line_count_r >= CNT_W'(1)) && (line_count_r <= CNT_W'(MAX_LINES)))
    else $error("line count out of range");

  // a pending cr always follows at least one byte
  a_pending_size: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (text_size_r != '0))
    else $error("pending cr on empty text");

  // a result is handed over only from the done step
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done step");

endmodule
